/* rtl/i2cbb_pkg.sv */
// ---------------------------------------------------------------------------
// i2cbb_pkg
// Types, codes and constants shared by the two-wire bus master.
// ---------------------------------------------------------------------------
package i2cbb_pkg;

  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = 8;
  localparam int unsigned TimerW   = 10;  // 4 units x 255 ticks fits in 10 bits

  localparam logic [7:0] TicksPerUnitRst = 8'd1;
  localparam logic [7:0] AckPollLimitRst = 8'd250;
  localparam logic [3:0] BitsPerByte     = 4'd8;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_TICKS_PER_UNIT = 1'b0,
    CFG_ACK_POLL_LIMIT = 1'b1
  } cfg_idx_e;

  typedef enum logic [2:0] {
    CMD_START    = 3'd0,
    CMD_STOP     = 3'd1,
    CMD_WRITE    = 3'd2,
    CMD_RD_ACK   = 3'd3,
    CMD_RD_NACK  = 3'd4,
    CMD_WAIT_ACK = 3'd5
  } cmd_e;

  typedef enum logic [3:0] {
    PH_IDLE     = 4'd0,
    PH_ST_A     = 4'd1,
    PH_ST_B     = 4'd2,
    PH_SP_A     = 4'd3,
    PH_SP_B     = 4'd4,
    PH_WR_SETUP = 4'd5,
    PH_WR_HIGH  = 4'd6,
    PH_WR_LOW   = 4'd7,
    PH_RD_LOW   = 4'd8,
    PH_RD_HIGH  = 4'd9,
    PH_AK_LOW   = 4'd10,
    PH_AK_HIGH  = 4'd11,
    PH_WA_POLL  = 4'd12
  } phase_e;

  typedef struct packed {
    logic       cmd_valid;
    logic [2:0] cmd;
    logic [7:0] wr_byte;
    logic       sda_in;
  } tick_t;

  typedef struct packed {
    logic       scl;
    logic       sda_out;
    logic       sda_is_output;
    logic       busy_res;
    logic       done_res;
    logic [7:0] rd_byte;
    logic       ack_missing;
  } res_t;

  typedef struct packed {
    logic [7:0] ticks_per_unit;
    logic [7:0] ack_poll_limit;
  } cfg_t;

endpackage

/* rtl/i2cbb_ifs.sv */
// ---------------------------------------------------------------------------
// i2cbb_ifs
// Valid/ready channels for the tick input and the result output.
// ---------------------------------------------------------------------------
interface i2cbb_in_if;
  logic       valid;
  logic       ready;
  logic       cmd_valid;
  logic [2:0] cmd;
  logic [7:0] wr_byte;
  logic       sda_in;

  modport source (output valid, output cmd_valid, output cmd, output wr_byte,
                  output sda_in, input ready);
  modport sink   (input valid, input cmd_valid, input cmd, input wr_byte,
                  input sda_in, output ready);
endinterface

interface i2cbb_out_if;
  logic       valid;
  logic       ready;
  logic       scl;
  logic       sda_out;
  logic       sda_is_output;
  logic       busy_res;
  logic       done_res;
  logic [7:0] rd_byte;
  logic       ack_missing;

  modport source (output valid, output scl, output sda_out, output sda_is_output,
                  output busy_res, output done_res, output rd_byte,
                  output ack_missing, input ready);
  modport sink   (input valid, input scl, input sda_out, input sda_is_output,
                  input busy_res, input done_res, input rd_byte,
                  input ack_missing, output ready);
endinterface

/* rtl/i2cbb_in_stage.sv */
// ---------------------------------------------------------------------------
// i2cbb_in_stage
// Input register: captures one tick and holds it until the sequencer takes it.
// ---------------------------------------------------------------------------
module i2cbb_in_stage
  import i2cbb_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  input  tick_t in_tick_i,
  output logic  tick_valid_o,
  input  logic  tick_take_i,
  output tick_t tick_o
);

  logic  valid_q;
  tick_t tick_q;

  assign in_ready_o   = !valid_q || tick_take_i;
  assign tick_valid_o = valid_q;
  assign tick_o       = tick_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      tick_q <= in_tick_i;
    end
  end

endmodule

/* rtl/i2cbb_seq.sv */
// ---------------------------------------------------------------------------
// i2cbb_seq
// Bus sequencer: phase, timer and shift state, advanced once per committed tick.
// ---------------------------------------------------------------------------
module i2cbb_seq
  import i2cbb_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  cfg_t  cfg_i,
  input  logic  commit_i,
  input  tick_t tick_i,
  output res_t  res_o
);

  phase_e            phase_q, phase_d;
  logic [3:0]        bit_cnt_q, bit_cnt_d;
  logic [TimerW-1:0] timer_q, timer_d;
  logic [7:0]        shift_q, shift_d;
  logic [7:0]        poll_q, poll_d;
  logic              scl_q, scl_d;
  logic              sda_q, sda_d;
  logic              dir_q, dir_d;
  logic              err_q, err_d;
  logic [7:0]        rd_last_q, rd_last_d;
  logic              nack_q, nack_d;
  logic              done;

  logic [7:0]        unit_eff;
  logic [TimerW-1:0] t1, t2, t4;
  logic [7:0]        poll_cur;
  logic              do_poll;
  logic [3:0]        bit_cnt_inc;
  logic [7:0]        shift_in;

  // a zero tick count behaves as one
  assign unit_eff    = (cfg_i.ticks_per_unit == 8'd0) ? 8'd1 : cfg_i.ticks_per_unit;
  assign t1          = {2'b00, unit_eff};
  assign t2          = {1'b0, unit_eff, 1'b0};
  assign t4          = {unit_eff, 2'b00};
  assign bit_cnt_inc = bit_cnt_q + 4'd1;
  assign shift_in    = {shift_q[6:0], tick_i.sda_in};

  always_comb begin
    phase_d   = phase_q;
    bit_cnt_d = bit_cnt_q;
    timer_d   = timer_q;
    shift_d   = shift_q;
    poll_d    = poll_q;
    scl_d     = scl_q;
    sda_d     = sda_q;
    dir_d     = dir_q;
    err_d     = err_q;
    rd_last_d = rd_last_q;
    nack_d    = nack_q;
    done      = 1'b0;
    do_poll   = 1'b0;
    poll_cur  = poll_q;

    if (phase_q == PH_IDLE) begin
      if (tick_i.cmd_valid && (tick_i.cmd <= CMD_WAIT_ACK)) begin
        err_d     = 1'b0;
        bit_cnt_d = 4'd0;
        case (cmd_e'(tick_i.cmd))
          CMD_START: begin
            dir_d   = 1'b1;
            sda_d   = 1'b1;
            scl_d   = 1'b1;
            phase_d = PH_ST_A;
            timer_d = t4;
          end
          CMD_STOP: begin
            dir_d   = 1'b1;
            scl_d   = 1'b0;
            sda_d   = 1'b0;
            phase_d = PH_SP_A;
            timer_d = t4;
          end
          CMD_WRITE: begin
            dir_d   = 1'b1;
            scl_d   = 1'b0;
            sda_d   = tick_i.wr_byte[7];
            shift_d = {tick_i.wr_byte[6:0], 1'b0};
            phase_d = PH_WR_SETUP;
            timer_d = t2;
          end
          CMD_RD_ACK, CMD_RD_NACK: begin
            nack_d  = (tick_i.cmd == CMD_RD_NACK);
            dir_d   = 1'b0;
            scl_d   = 1'b0;
            shift_d = 8'd0;
            phase_d = PH_RD_LOW;
            timer_d = t2;
          end
          default: begin
            // wait for ack: release the line and poll on this very tick
            dir_d    = 1'b0;
            scl_d    = 1'b1;
            poll_cur = 8'd0;
            poll_d   = 8'd0;
            phase_d  = PH_WA_POLL;
            timer_d  = '0;
            do_poll  = 1'b1;
          end
        endcase
      end
    end else if (phase_q == PH_WA_POLL) begin
      do_poll = 1'b1;
    end else if (timer_q > t1 - t1 + 10'd1) begin
      timer_d = timer_q - 10'd1;
    end else begin
      case (phase_q)
        PH_ST_A: begin
          sda_d   = 1'b0;
          phase_d = PH_ST_B;
          timer_d = t4;
        end
        PH_ST_B: begin
          scl_d   = 1'b0;
          phase_d = PH_IDLE;
          timer_d = '0;
          done    = 1'b1;
        end
        PH_SP_A: begin
          scl_d   = 1'b1;
          sda_d   = 1'b1;
          phase_d = PH_SP_B;
          timer_d = t4;
        end
        PH_WR_SETUP: begin
          scl_d   = 1'b1;
          phase_d = PH_WR_HIGH;
          timer_d = t2;
        end
        PH_WR_HIGH: begin
          scl_d   = 1'b0;
          phase_d = PH_WR_LOW;
          timer_d = t2;
        end
        PH_WR_LOW: begin
          bit_cnt_d = bit_cnt_inc;
          if (bit_cnt_inc >= BitsPerByte) begin
            phase_d = PH_IDLE;
            timer_d = '0;
            done    = 1'b1;
          end else begin
            sda_d   = shift_q[7];
            shift_d = {shift_q[6:0], 1'b0};
            phase_d = PH_WR_SETUP;
            timer_d = t2;
          end
        end
        PH_RD_LOW: begin
          scl_d     = 1'b1;
          shift_d   = shift_in;
          bit_cnt_d = bit_cnt_inc;
          if (bit_cnt_inc >= BitsPerByte) begin
            rd_last_d = shift_in;
          end
          phase_d = PH_RD_HIGH;
          timer_d = t1;
        end
        PH_RD_HIGH: begin
          scl_d = 1'b0;
          if (bit_cnt_q >= BitsPerByte) begin
            dir_d   = 1'b1;
            sda_d   = nack_q;
            phase_d = PH_AK_LOW;
          end else begin
            phase_d = PH_RD_LOW;
          end
          timer_d = t2;
        end
        PH_AK_LOW: begin
          scl_d   = 1'b1;
          phase_d = PH_AK_HIGH;
          timer_d = t2;
        end
        PH_AK_HIGH: begin
          scl_d   = 1'b0;
          phase_d = PH_IDLE;
          timer_d = '0;
          done    = 1'b1;
        end
        default: begin
          // end of stop hold and any unused phase code
          phase_d = PH_IDLE;
          timer_d = '0;
          done    = 1'b1;
        end
      endcase
    end

    if (do_poll) begin
      if (!tick_i.sda_in) begin
        scl_d   = 1'b0;
        phase_d = PH_IDLE;
        timer_d = '0;
        done    = 1'b1;
      end else if (poll_cur >= cfg_i.ack_poll_limit) begin
        // timed out: flag and issue stop
        err_d   = 1'b1;
        dir_d   = 1'b1;
        scl_d   = 1'b0;
        sda_d   = 1'b0;
        phase_d = PH_SP_A;
        timer_d = t4;
      end else begin
        poll_d = poll_cur + 8'd1;
      end
    end
  end

  always_comb begin
    res_o.scl           = scl_d;
    res_o.sda_out       = dir_d & sda_d;
    res_o.sda_is_output = dir_d;
    res_o.busy_res      = (phase_d != PH_IDLE);
    res_o.done_res      = done;
    res_o.rd_byte       = rd_last_d;
    res_o.ack_missing   = err_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_IDLE;
      bit_cnt_q <= 4'd0;
      timer_q   <= '0;
      shift_q   <= 8'd0;
      poll_q    <= 8'd0;
      scl_q     <= 1'b1;
      sda_q     <= 1'b1;
      dir_q     <= 1'b1;
      err_q     <= 1'b0;
      rd_last_q <= 8'd0;
      nack_q    <= 1'b0;
    end else if (commit_i) begin
      phase_q   <= phase_d;
      bit_cnt_q <= bit_cnt_d;
      timer_q   <= timer_d;
      shift_q   <= shift_d;
      poll_q    <= poll_d;
      scl_q     <= scl_d;
      sda_q     <= sda_d;
      dir_q     <= dir_d;
      err_q     <= err_d;
      rd_last_q <= rd_last_d;
      nack_q    <= nack_d;
    end
  end

  // a timed phase always holds a live count
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q != PH_IDLE && phase_q != PH_WA_POLL) |-> (timer_q != '0))
    else $error("timed phase with zero timer");

  // hold ticks count down by exactly one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (commit_i && phase_q != PH_IDLE && phase_q != PH_WA_POLL && timer_q > 10'd1)
    |=> (timer_q == $past(timer_q) - 10'd1))
    else $error("hold timer did not count down");

  // the error flag only rises when the stop sequence is launched
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(err_q) |-> (phase_q == PH_SP_A && dir_q && !scl_q))
    else $error("ack error without stop sequence");

  // state only moves on a committed tick
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !commit_i |=> $stable(phase_q) && $stable(timer_q))
    else $error("sequencer state moved without a tick");

endmodule

/* rtl/i2cbb_out_stage.sv */
// ---------------------------------------------------------------------------
// i2cbb_out_stage
// Result register: holds one result until the consumer takes it.
// ---------------------------------------------------------------------------
module i2cbb_out_stage
  import i2cbb_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic res_valid_i,
  output logic res_ready_o,
  input  res_t res_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output res_t res_o
);

  logic valid_q;
  res_t res_q;

  assign res_ready_o = !valid_q || out_ready_i;
  assign out_valid_o = valid_q;
  assign res_o       = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (res_ready_o) begin
      valid_q <= res_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid_i && res_ready_o) begin
      res_q <= res_i;
    end
  end

  // a finished command never reports itself busy
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && res_q.done_res) |-> !res_q.busy_res)
    else $error("done result flagged busy");

  // released data line reads as low
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && !res_q.sda_is_output) |-> !res_q.sda_out)
    else $error("data driven while released");

endmodule

/* rtl/i2c_bitbang_master.sv */
// ---------------------------------------------------------------------------
// i2c_bitbang_master
// Two-wire bus master bit-banged from a tick stream, one result per tick.
//
//   channel  dir  handshake        payload
//   in_if    in   valid / ready    cmd_valid, cmd, wr_byte, sda_in
//   out_if   out  valid / ready    scl, sda_out, sda_is_output, busy_res,
//                                  done_res, rd_byte, ack_missing
//   cfg      in   cfg_we_i         cfg_idx_i, cfg_wdata_i
//
// One tick per clock cycle while the output is not stalled; a tick passes
// through the input register and the sequencer logic into the result register.
// Reset puts the bus lines high and driven, the sequencer idle and the
// registers at one tick per unit and 250 ack polls.
// A stalled output holds its result; the input stage keeps taking ticks until
// both registers are full.
// ---------------------------------------------------------------------------
module i2c_bitbang_master
  import i2cbb_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  i2cbb_in_if.sink            in_if,
  i2cbb_out_if.source         out_if
);

  cfg_t  cfg_q;
  tick_t in_tick;
  tick_t tick;
  logic  tick_valid;
  logic  res_ready;
  logic  commit;
  res_t  res_next;
  res_t  res_out;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.ticks_per_unit <= TicksPerUnitRst;
      cfg_q.ack_poll_limit <= AckPollLimitRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_TICKS_PER_UNIT: cfg_q.ticks_per_unit <= cfg_wdata_i;
        CFG_ACK_POLL_LIMIT: cfg_q.ack_poll_limit <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign in_tick.cmd_valid = in_if.cmd_valid;
  assign in_tick.cmd       = in_if.cmd;
  assign in_tick.wr_byte   = in_if.wr_byte;
  assign in_tick.sda_in    = in_if.sda_in;

  assign commit = tick_valid && res_ready;

  i2cbb_in_stage u_in_stage (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_if.valid),
    .in_ready_o   (in_if.ready),
    .in_tick_i    (in_tick),
    .tick_valid_o (tick_valid),
    .tick_take_i  (commit),
    .tick_o       (tick)
  );

  i2cbb_seq u_seq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg_q),
    .commit_i (commit),
    .tick_i   (tick),
    .res_o    (res_next)
  );

  i2cbb_out_stage u_out_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_valid_i (tick_valid),
    .res_ready_o (res_ready),
    .res_i       (res_next),
    .out_valid_o (out_if.valid),
    .out_ready_i (out_if.ready),
    .res_o       (res_out)
  );

  assign out_if.scl           = res_out.scl;
  assign out_if.sda_out       = res_out.sda_out;
  assign out_if.sda_is_output = res_out.sda_is_output;
  assign out_if.busy_res      = res_out.busy_res;
  assign out_if.done_res      = res_out.done_res;
  assign out_if.rd_byte       = res_out.rd_byte;
  assign out_if.ack_missing   = res_out.ack_missing;

endmodule
